[design/sae_pkg.sv]
// Package: sizes, opcodes, status codes and helpers for the sorted adjacency edge store.
`default_nettype none
package sae_pkg;
  localparam int MaxNodes   = 16;
  localparam int MaxDegree  = 8;
  localparam int WeightBits = 32;
  localparam int NodeW  = $clog2(MaxNodes);
  localparam int PosW   = $clog2(MaxDegree);
  localparam int DegW   = $clog2(MaxDegree + 1);
  localparam int AddrW  = NodeW + PosW;
  localparam int Slots  = MaxNodes * MaxDegree;
  localparam int ActW   = 5;
  localparam int CntW   = 8;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_UPD = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;
  localparam logic [1:0] OP_RD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [0:0] REG_DIRECTED = 1'b0;
  localparam logic [0:0] REG_ACTIVE   = 1'b1;

  typedef logic signed [WeightBits-1:0] weight_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] tgt;
    weight_t          w;
    logic [PosW-1:0]  slot;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CntW-1:0]  total;
    logic [3:0]       degree;
    logic             valid;
    logic [3:0]       nbr;
    logic [31:0]      weight;
  } result_t;

  function automatic weight_t clamp_in(input logic signed [31:0] v);
    weight_t r;
    logic signed [63:0] e;
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    e  = 64'(v);
    mx = (64'sd1 <<< (WeightBits - 1)) - 64'sd1;
    mn = -mx - 64'sd1;
    if (e > mx) r = weight_t'(mx);
    else if (e < mn) r = weight_t'(mn);
    else r = weight_t'(e);
    return r;
  endfunction

  function automatic weight_t sat_add(input weight_t a, input weight_t b);
    logic signed [WeightBits:0] s;
    weight_t r;
    s = {a[WeightBits-1], a} + {b[WeightBits-1], b};
    if (s[WeightBits] != s[WeightBits-1])
      r = s[WeightBits] ? {1'b1, {(WeightBits-1){1'b0}}} : {1'b0, {(WeightBits-1){1'b1}}};
    else
      r = s[WeightBits-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

[design/sae_stream_if.sv]
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface sae_stream_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/sorted_adjacency_edge_store.sv]
// Top level of the sorted adjacency edge store.
// Use: item channel in_ch (sink) takes one operation: add, update weight,
// remove, or read a neighbor slot. Result channel out_ch (source) returns
// one result per item: status, edge count, list degree and read slot.
// Configuration: cfg_we/cfg_index/cfg_data write directed_mode (0) and
// active_nodes (1); write only while idle.
// Sequence: each list is scanned entry by entry, then a decide state, then each
// acted-on list is shifted entry by entry with a final write, then an output
// state. Each scanned or shifted entry takes an address phase and a data
// phase on the single-port list memories. A plain read returns the slot
// addressed while idle and scans no list.
// One item is worked on at a time.
// The result register frees the datapath: the next item is taken while a
// finished result still waits; a stalled receiver holds the result and
// blocks the next completion only.
// Reset: degrees, edge count, state, configuration and result valid clear at
// once; list memories are not cleared and need no sweep.
`default_nettype none
module sorted_adjacency_edge_store (
  input  wire logic        clk,
  input  wire logic        rst,
  sae_stream_if.sink       in_ch,
  sae_stream_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import sae_pkg::*;
  logic directed;
  logic [4:0] active;
  logic [3:0] state;
  logic busy, start, scan_done, shift_done, two_lists, do_write, out_free, res_valid;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      directed <= 1'b0;
      active <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DIRECTED) directed <= cfg_data[0];
      else active <= cfg_data;
    end
  end

  assign in_ch.ready = !busy;
  assign start = in_ch.valid && !busy;

  sae_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .scan_done(scan_done),
    .shift_done(shift_done), .two_lists(two_lists), .do_write(do_write),
    .out_free(out_free), .state(state), .busy(busy));

  sae_dp u_dp (
    .clk(clk), .rst(rst), .state(state), .start(start), .item(in_ch.data),
    .directed(directed), .active(active), .res_take(out_ch.ready && res_valid),
    .scan_done(scan_done), .shift_done(shift_done), .two_lists(two_lists),
    .do_write(do_write), .out_free(out_free), .res_valid(res_valid), .res(res));

  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;
endmodule
`default_nettype wire

[design/sae_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module sae_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[design/sae_ctrl.sv]
// Controller: sequences scans, shifts and writes for one operation.
`default_nettype none
module sae_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic scan_done,
  input  wire logic shift_done,
  input  wire logic two_lists,
  input  wire logic do_write,
  input  wire logic out_free,
  output logic [3:0] state,
  output logic       busy
);
  import sae_pkg::*;
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN0 = 4'd1;
  localparam logic [3:0] S_SCAN1 = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SH0   = 4'd4;
  localparam logic [3:0] S_SH1   = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  logic [3:0] state_next;
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_SCAN0;
      S_SCAN0: if (scan_done) state_next = two_lists ? S_SCAN1 : S_DEC;
      S_SCAN1: if (scan_done) state_next = S_DEC;
      S_DEC:   state_next = do_write ? S_SH0 : S_DONE;
      S_SH0:   if (shift_done) state_next = two_lists ? S_SH1 : S_DONE;
      S_SH1:   if (shift_done) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

[design/sae_dp.sv]
// Datapath: list memories, degree table, scan and shift engine, result register.
`default_nettype none
module sae_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [3:0]       state,
  input  wire logic             start,
  input  wire sae_pkg::item_t   item,
  input  wire logic             directed,
  input  wire logic [4:0]       active,
  input  wire logic             res_take,
  output logic                  scan_done,
  output logic                  shift_done,
  output logic                  two_lists,
  output logic                  do_write,
  output logic                  out_free,
  output logic                  res_valid,
  output sae_pkg::result_t      res
);
  import sae_pkg::*;
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN0 = 4'd1;
  localparam logic [3:0] S_SCAN1 = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SH0   = 4'd4;
  localparam logic [3:0] S_SH1   = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  localparam logic [1:0] MODE_INS  = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  item_t it;
  logic [DegW-1:0] deg [MaxNodes];
  logic [CntW-1:0] total;
  // scan state per list: pos found, hit flag
  logic [DegW-1:0] pos0, pos1;
  logic hit0, hit1, stop0, stop1;
  logic [DegW-1:0] cnt;
  logic ph;           // 0: address issued, 1: data back
  logic s_ok, t_ok, und;
  logic [1:0] mode;   // insert/merge, weight set, erase, none
  logic m0, m1;
  weight_t wsel;
  logic [1:0] stat;

  // read data for read op is captured right after the idle-state address
  logic [NodeW-1:0] rd_id;
  weight_t rd_w;
  logic was_idle;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [NodeW-1:0] ram_id_wd, ram_id_rd;
  weight_t ram_w_wd, ram_w_rd;

  sae_ram #(.Width(NodeW), .Depth(Slots)) u_ids (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_id_wd), .rdata(ram_id_rd));
  sae_ram #(.Width(WeightBits), .Depth(Slots)) u_wts (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_w_wd), .rdata(ram_w_rd));

  logic [4:0] lim;
  assign lim = (active > 5'(MaxNodes)) ? 5'(MaxNodes) : active;

  logic sec;  // second list (mirror) selected
  assign sec = (state == S_SCAN1) || (state == S_SH1);
  logic [NodeW-1:0] node, key;
  assign node = sec ? it.tgt : it.src;
  assign key  = sec ? it.src : it.tgt;
  logic [DegW-1:0] ndeg;
  assign ndeg = deg[node];
  logic [DegW-1:0] fpos;
  logic fhit;
  assign fpos = sec ? pos1 : pos0;
  assign fhit = sec ? hit1 : hit0;
  logic act;  // this list is acted on in shift phase
  assign act = sec ? m1 : m0;

  // shift phase: insert walks i from deg down to pos+1 (copy i-1 -> i) then writes pos;
  // erase walks i from pos to deg-2 (copy i+1 -> i); set writes pos.
  logic [DegW-1:0] rd_i, wr_i;
  logic wr_last;
  always_comb begin
    rd_i = cnt; wr_i = cnt; wr_last = 1'b0;
    if (state == S_SH0 || state == S_SH1) begin
      if (!act || mode == MODE_NONE) begin
        wr_last = 1'b1;
      end else if (mode == MODE_INS) begin
        rd_i = cnt - 1'b1;
        wr_last = (cnt == fpos);
      end else if (mode == MODE_DEL) begin
        rd_i = cnt + 1'b1;
        wr_last = (cnt + 1'b1 >= ndeg);
      end else begin
        wr_last = 1'b1;
      end
    end
  end

  weight_t neww;
  always_comb begin
    ram_we = 1'b0;
    ram_addr = {node, cnt[PosW-1:0]};
    ram_id_wd = ram_id_rd;
    ram_w_wd = ram_w_rd;
    neww = fhit ? sat_add(ram_w_rd, wsel) : wsel;
    if (state == S_IDLE) begin
      ram_addr = {item.src, item.slot};
    end else if (state == S_SH0 || state == S_SH1) begin
      if (act && mode != MODE_NONE) begin
        if (mode == MODE_SET || (mode == MODE_INS && cnt == fpos)) begin
          ram_addr = {node, fpos[PosW-1:0]};
          ram_we = ph;
          ram_id_wd = key;
          ram_w_wd = (mode == MODE_SET) ? wsel : neww;
        end else if (mode == MODE_DEL && cnt + 1'b1 >= ndeg) begin
          ram_we = 1'b0;
        end else begin
          ram_addr = ph ? {node, wr_i[PosW-1:0]} : {node, rd_i[PosW-1:0]};
          ram_we = ph;
        end
      end
    end
  end

  assign scan_done = (state == S_SCAN0 || state == S_SCAN1) &&
                     ((sec ? stop1 : stop0) || (ph && (ram_id_rd >= key || cnt + 1'b1 >= ndeg))
                      || ndeg == '0);
  assign shift_done = wr_last && (ph || !act || mode == MODE_NONE ||
                      (mode == MODE_DEL && cnt + 1'b1 >= ndeg));
  assign out_free = !res_valid || res_take;
  logic full0, full1;
  assign full0 = !hit0 && deg[it.src] >= DegW'(MaxDegree);
  assign full1 = und && it.src != it.tgt && !hit1 && deg[it.tgt] >= DegW'(MaxDegree);

  always_comb begin
    two_lists = 1'b0;
    if (state == S_SCAN0 || state == S_SCAN1) two_lists = und && it.op != OP_RD;
    else two_lists = m1;
    // decided from the scan results, valid while in S_DEC
    do_write = (it.op != OP_RD) && s_ok && t_ok &&
               ((it.op == OP_ADD) ? !(full0 || full1) : hit0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxNodes; i++) deg[i] <= '0;
      total <= '0;
      res_valid <= 1'b0;
      ph <= 1'b0; cnt <= '0;
    end else begin
      if (state == S_DONE && out_free) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            it <= item;
            wsel <= clamp_in(item.w);
            s_ok <= 5'(item.src) < lim;
            t_ok <= 5'(item.tgt) < lim;
            und <= !directed;
            pos0 <= '0; pos1 <= '0; hit0 <= 1'b0; hit1 <= 1'b0;
            stop0 <= 1'b0; stop1 <= 1'b0;
            cnt <= '0; ph <= 1'b0;
          end
        end
        S_SCAN0, S_SCAN1: begin
          if (it.op == OP_RD || ndeg == '0) begin
            if (sec) stop1 <= 1'b1; else stop0 <= 1'b1;
            if (sec) pos1 <= '0; else pos0 <= '0;
            cnt <= '0; ph <= 1'b0;
          end else if (!ph) begin
            ph <= 1'b1;
          end else begin
            if (ram_id_rd >= key || cnt + 1'b1 >= ndeg) begin
              if (sec) begin
                pos1 <= (ram_id_rd >= key) ? cnt : cnt + 1'b1;
                hit1 <= ram_id_rd == key;
              end else begin
                pos0 <= (ram_id_rd >= key) ? cnt : cnt + 1'b1;
                hit0 <= ram_id_rd == key;
              end
              cnt <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
            ph <= 1'b0;
          end
        end
        S_DEC: begin
          m0 <= 1'b0; m1 <= 1'b0; mode <= MODE_NONE; stat <= ST_OK;
          if (it.op == OP_RD) begin
            stat <= s_ok ? ST_OK : ST_RANGE;
          end else if (!s_ok || !t_ok) begin
            stat <= ST_RANGE;
          end else if (it.op == OP_ADD) begin
            if (full0 || full1) stat <= ST_FULL;
            else begin
              // insert or merge; merge uses same write slot with sat add
              mode <= MODE_INS; m0 <= 1'b1; m1 <= und;
              if (!hit0 && total != 8'hFF) total <= total + 1'b1;
            end
          end else if (!hit0) begin
            stat <= ST_MISS;
          end else if (it.op == OP_UPD) begin
            mode <= MODE_SET; m0 <= 1'b1; m1 <= und && hit1;
          end else begin
            mode <= MODE_DEL; m0 <= 1'b1; m1 <= und && hit1 && it.src != it.tgt;
            if (total != '0) total <= total - 1'b1;
          end
          cnt <= (it.op == OP_REM) ? pos0 : (hit0 ? pos0 : deg[it.src]);
          ph <= 1'b0;
        end
        S_SH0, S_SH1: begin
          if (shift_done) begin
            // degree bookkeeping for this list
            if (act && mode == MODE_INS && !fhit) deg[node] <= ndeg + 1'b1;
            if (act && mode == MODE_DEL) deg[node] <= ndeg - 1'b1;
            // undirected self-loop: second merge on the same list
            if (!sec && m1 && mode == MODE_INS && it.src == it.tgt) begin
              hit1 <= 1'b1; pos1 <= pos0;
            end
            if (!sec) begin
              if (mode == MODE_DEL) cnt <= pos1;
              else if (mode == MODE_INS) cnt <= (it.src == it.tgt) ? pos0 :
                                                (hit1 ? pos1 : deg[it.tgt]);
              else cnt <= pos1;
            end
            ph <= 1'b0;
          end else if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (mode == MODE_INS && cnt != fpos) cnt <= cnt - 1'b1;
            else if (mode == MODE_DEL) cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res.status <= stat;
            res.total <= total;
            res.degree <= s_ok ? 4'(deg[it.src]) : 4'd0;
            res.valid <= 1'b0; res.nbr <= '0; res.weight <= '0;
            if (it.op == OP_RD && s_ok && DegW'(it.slot) < deg[it.src]) begin
              res.valid <= 1'b1;
              res.nbr <= 4'(rd_id);
              res.weight <= 32'(rd_w);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) was_idle <= 1'b0;
    else was_idle <= (state == S_IDLE) && start;
    if (was_idle) begin
      rd_id <= ram_id_rd;
      rd_w <= ram_w_rd;
    end
  end
endmodule
`default_nettype wire

[design/sae_checker.sv]
// Port-level checker for the edge store, bound to the top level.
`default_nettype none
module sae_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_status,
  input wire logic out_slot_valid
);
  import sae_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
  a_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_slot_valid |-> out_status == ST_OK) else $error("slot with error");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
endmodule

bind sorted_adjacency_edge_store sae_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status), .out_slot_valid(out_ch.data.valid));
`default_nettype wire
